@@ rtl/ps2md_pkg.sv @@
package ps2md_pkg;

  localparam int unsigned RingDepthDefault = 32;

  localparam logic [7:0] SyncMask  = 8'h08;
  localparam logic [7:0] OvfXMask  = 8'h40;
  localparam logic [7:0] OvfYMask  = 8'h80;
  localparam logic [7:0] BtnMask   = 8'h07;

  localparam int unsigned DxW    = 9;
  localparam int unsigned DyW    = 10;
  localparam int unsigned PosW   = 32;
  localparam int unsigned BtnW   = 3;
  localparam int unsigned EntryW = DxW + DyW + 2 * PosW + BtnW;
  localparam int unsigned OutDataW = ((EntryW + 7) / 8) * 8;
  localparam int unsigned InDataW  = 16;

  localparam logic OpByte = 1'b0;
  localparam logic OpRead = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [BtnW-1:0]   buttons;
    logic [PosW-1:0]   pos_y;
    logic [PosW-1:0]   pos_x;
    logic [DyW-1:0]    delta_y;
    logic [DxW-1:0]    delta_x;
  } evt_t;

endpackage

@@ rtl/ps2md_assembler.sv @@
module ps2md_assembler import ps2md_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] byte_i,
  output evt_t       evt_o
);

  logic [1:0]      count_q, count_d;
  logic [7:0]      first_q, first_d;
  logic [7:0]      second_q, second_d;
  logic [PosW-1:0] cur_x_q, cur_x_d;
  logic [PosW-1:0] cur_y_q, cur_y_d;

  logic            finish;
  logic            good;
  logic [DxW-1:0]  dx;
  logic [DyW-1:0]  dy;

  assign finish = byte_valid_i && (count_q[1] == 1'b1);
  assign good   = ((first_q & (OvfXMask | OvfYMask)) == 8'h00);
  assign dx     = {first_q[4], second_q};
  assign dy     = {1'b0, first_q[5], 8'h00} - {2'b00, byte_i};

  always_comb begin
    count_d  = count_q;
    first_d  = first_q;
    second_d = second_q;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    if (byte_valid_i) begin
      unique case (count_q)
        2'd0: begin
          if ((byte_i & SyncMask) != 8'h00) begin
            first_d = byte_i;
            count_d = 2'd1;
          end
        end
        2'd1: begin
          second_d = byte_i;
          count_d  = 2'd2;
        end
        default: begin
          count_d = 2'd0;
          if (good) begin
            cur_x_d = cur_x_q + {{(PosW-DxW){dx[DxW-1]}}, dx};
            cur_y_d = cur_y_q + {{(PosW-DyW){dy[DyW-1]}}, dy};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      first_q  <= 8'h00;
      second_q <= 8'h00;
      cur_x_q  <= '0;
      cur_y_q  <= '0;
    end else begin
      count_q  <= count_d;
      first_q  <= first_d;
      second_q <= second_d;
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
    end
  end

  assign evt_o.valid   = finish && good;
  assign evt_o.buttons = BtnW'(first_q & BtnMask);
  assign evt_o.pos_x   = cur_x_d;
  assign evt_o.pos_y   = cur_y_d;
  assign evt_o.delta_y = dy;
  assign evt_o.delta_x = dx;

endmodule

@@ rtl/ps2_mouse_packet_decoder.sv @@
// PS/2 mouse packet decoder with an event ring.
// Slave channel: one beat per controller byte or read request. tuser is the
// operation (byte or read); tdata carries the byte and the aux-port flag.
// Bytes are taken only while the enable register is set and the byte came
// from the aux port; three bytes form a packet. With no overflow bit set its
// deltas add to the wrapping 32-bit cursor; a non-full ring queues the event.
// Master channel: one beat per read request. tuser is the event-valid flag;
// tdata is all zero when the ring was empty.
// Throughput: one beat per cycle on the slave side while the output is not
// stalled. A read result is registered by the ring read port and appears in
// the cycle after the read is accepted. Byte beats produce no output beat.
// Reset clears the packet state, cursor, pointers and enable; the ring
// content itself is not cleared (only written entries are ever read).
// When the receiver stalls, the result holds in the output register and the
// slave side stalls until it is taken.
module ps2_mouse_packet_decoder import ps2md_pkg::*; #(
  parameter int unsigned RING_DEPTH = RingDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // data_byte[7:0], from_aux[8]
  input  logic                s_axis_tuser_i,   // operation
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,   // delta_x, delta_y, pos_x, pos_y, button_bits
  output logic                m_axis_tuser_o    // event_valid
);

  localparam int unsigned PtrW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [PtrW-1:0] LastPtr = PtrW'(RING_DEPTH - 1);

  logic              enabled_q;
  logic [PtrW-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [PtrW-1:0]   wp_nxt, rp_nxt;
  logic              out_vld_q, out_vld_d;
  logic              out_evt_q, out_evt_d;
  logic [EntryW-1:0] rdata_q;
  logic [EntryW-1:0] mem [RING_DEPTH];

  logic        accept, byte_take, rd_take, rd_pop, empty, full, push;
  evt_t        evt;
  logic [EntryW-1:0] wentry;

  assign s_axis_tready_o = !out_vld_q || m_axis_tready_i;
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign byte_take = accept && (s_axis_tuser_i == OpByte) && s_axis_tdata_i[8] && enabled_q;
  assign rd_take   = accept && (s_axis_tuser_i == OpRead);

  assign wp_nxt = (wp_q == LastPtr) ? '0 : wp_q + 1'b1;
  assign rp_nxt = (rp_q == LastPtr) ? '0 : rp_q + 1'b1;
  assign empty  = (wp_q == rp_q);
  assign full   = (wp_nxt == rp_q);
  assign rd_pop = rd_take && !empty;

  ps2md_assembler u_asm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(byte_take),
    .byte_i      (s_axis_tdata_i[7:0]),
    .evt_o       (evt)
  );

  assign push   = evt.valid && !full;
  assign wentry = {evt.buttons, evt.pos_y, evt.pos_x, evt.delta_y, evt.delta_x};

  always_comb begin
    wp_d      = push   ? wp_nxt : wp_q;
    rp_d      = rd_pop ? rp_nxt : rp_q;
    out_vld_d = out_vld_q;
    out_evt_d = out_evt_q;
    if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
    if (rd_take) begin
      out_vld_d = 1'b1;
      out_evt_d = !empty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      wp_q      <= '0;
      rp_q      <= '0;
      out_vld_q <= 1'b0;
      out_evt_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        enabled_q <= cfg_wdata_i;
      end
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      out_vld_q <= out_vld_d;
      out_evt_q <= out_evt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wp_q] <= wentry;
    end
    if (rd_take) begin
      rdata_q <= mem[rp_q];
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_evt_q;
  assign m_axis_tdata_o  = {{(OutDataW-EntryW){1'b0}}, (out_evt_q ? rdata_q : '0)};

  ASSERT_PTR_RANGE: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(wp_q) < RING_DEPTH) && (32'(rp_q) < RING_DEPTH))
    else $error("ring pointer out of range");

  ASSERT_POP_FLAG: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_take |=> (m_axis_tvalid_o && (m_axis_tuser_o == $past(!empty))))
    else $error("read result flag mismatch");

  ASSERT_EMPTY_ZERO: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("empty result carries data");

  ASSERT_RP_MOVE: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rp_q != $past(rp_q)) |-> $past(rd_pop))
    else $error("read pointer moved without pop");

  ASSERT_NO_OVERRUN: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(push && !rd_pop) |-> (wp_q != rp_q))
    else $error("ring overrun");

endmodule
